// ===== src/axts_pkg.sv =====
// ---------------------------------------------------------------------------
// axts_pkg
// shared types, constants and aes byte functions for the xts block
// ---------------------------------------------------------------------------
package axts_pkg;

   localparam int unsigned NumCfg = 8;
   localparam int unsigned CfgIdxW = 3;
   localparam int unsigned RkDepth = 64;
   localparam int unsigned RkAddrW = 6;
   localparam int unsigned NumRounds = 14;
   localparam logic [63:0] GfPoly = 64'h87;
   localparam logic [7:0] RconInit = 8'h01;

   // forward s-box, entry 0 in the top byte
   localparam logic [2047:0] FwdTab = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXP_RD,
      ST_EXP_WAIT,
      ST_EXP_CALC,
      ST_TW_LOAD,
      ST_TW_RUN,
      ST_DT_LOAD,
      ST_DT_RUN,
      ST_DONE,
      ST_OUT,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic       start;
      logic       decrypt;
      logic [3:0] round;
      logic       last;
   } core_ctl_type;

   function automatic logic [7:0] xt(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] v;
      acc = 8'h00;
      v = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ v;
         end
         v = xt(v);
      end
      return acc;
   endfunction

   function automatic logic [2047:0] rev_table();
      logic [2047:0] r;
      logic [7:0]    v;
      logic [7:0]    idx;
      r = '0;
      for (int i = 0; i < 256; i++) begin
         idx = 8'(i);
         v = FwdTab[{~idx, 3'b111} -: 8];
         r[{~v, 3'b111} -: 8] = idx;
      end
      return r;
   endfunction

   localparam logic [2047:0] RevTab = rev_table();

   function automatic logic [7:0] fwd_sub(input logic [7:0] x);
      return FwdTab[{~x, 3'b111} -: 8];
   endfunction

   function automatic logic [7:0] rev_sub(input logic [7:0] x);
      return RevTab[{~x, 3'b111} -: 8];
   endfunction

endpackage

// ===== src/axts_round.sv =====
// ---------------------------------------------------------------------------
// axts_round
// one aes-256 round per cycle, encrypt or decrypt, state held locally
// ---------------------------------------------------------------------------
module axts_round (
   input  logic                  clock,
   input  axts_pkg::core_ctl_type ctl,
   input  logic [127:0]          load_data,
   input  logic [127:0]          round_key,
   output logic [127:0]          state_out
);

   logic [127:0] st_ff;
   logic [127:0] st_in;
   logic [7:0]   s  [16];
   logic [7:0]   t  [16];
   logic [7:0]   k  [16];
   logic [7:0]   m  [16];
   logic [7:0]   x;

   always_comb begin
      x = 8'h00;
      for (int i = 0; i < 16; i++) begin
         s[i] = st_ff[8*i +: 8];
         k[i] = round_key[8*i +: 8];
      end
      for (int i = 0; i < 16; i++) begin
         t[i] = 8'h00;
      end
      if (!ctl.decrypt) begin
         for (int i = 0; i < 16; i++) begin
            t[i] = axts_pkg::fwd_sub(s[(i + 4 * (i % 4)) % 16]);
         end
         for (int i = 0; i < 16; i++) begin
            m[i] = t[i];
         end
         if (!ctl.last) begin
            for (int c = 0; c < 16; c += 4) begin
               x = t[c] ^ t[c+1] ^ t[c+2] ^ t[c+3];
               m[c]   = t[c]   ^ x ^ axts_pkg::xt(t[c]   ^ t[c+1]);
               m[c+1] = t[c+1] ^ x ^ axts_pkg::xt(t[c+1] ^ t[c+2]);
               m[c+2] = t[c+2] ^ x ^ axts_pkg::xt(t[c+2] ^ t[c+3]);
               m[c+3] = t[c+3] ^ x ^ axts_pkg::xt(t[c+3] ^ t[c]);
            end
         end
         for (int i = 0; i < 16; i++) begin
            m[i] = m[i] ^ k[i];
         end
      end else begin
         for (int i = 0; i < 16; i++) begin
            t[(i + 4 * (i % 4)) % 16] = axts_pkg::rev_sub(s[i]);
         end
         for (int i = 0; i < 16; i++) begin
            t[i] = t[i] ^ k[i];
            m[i] = t[i];
         end
         if (!ctl.last) begin
            for (int c = 0; c < 16; c += 4) begin
               m[c]   = axts_pkg::gmul(t[c], 8'd14) ^ axts_pkg::gmul(t[c+1], 8'd11) ^
                        axts_pkg::gmul(t[c+2], 8'd13) ^ axts_pkg::gmul(t[c+3], 8'd9);
               m[c+1] = axts_pkg::gmul(t[c], 8'd9) ^ axts_pkg::gmul(t[c+1], 8'd14) ^
                        axts_pkg::gmul(t[c+2], 8'd11) ^ axts_pkg::gmul(t[c+3], 8'd13);
               m[c+2] = axts_pkg::gmul(t[c], 8'd13) ^ axts_pkg::gmul(t[c+1], 8'd9) ^
                        axts_pkg::gmul(t[c+2], 8'd14) ^ axts_pkg::gmul(t[c+3], 8'd11);
               m[c+3] = axts_pkg::gmul(t[c], 8'd11) ^ axts_pkg::gmul(t[c+1], 8'd13) ^
                        axts_pkg::gmul(t[c+2], 8'd9) ^ axts_pkg::gmul(t[c+3], 8'd14);
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         st_in[8*i +: 8] = m[i];
      end
      if (ctl.start) begin
         st_in = load_data ^ round_key;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign state_out = st_ff;

endmodule

// ===== src/aes256_xts_cipher_top.sv =====
// ---------------------------------------------------------------------------
// aes256_xts_cipher_top
// xts-aes-256 over one 16-byte block per item, round keys in memory
// ---------------------------------------------------------------------------
// request channel: req_valid/req_stall with first_block, decrypt, iv and data.
// response channel: rsp_valid/rsp_stall with out_lo/out_hi.
// csr port: csr_write, csr_index, csr_data write the eight key words.
// after a key write the next item first expands both keys into the round
// key memory: 15 entries per key, two copied from the key words and the rest
// each by reading the entry eight words back and then computing it.
// an item is taken in idle; its result is valid after the load, the key add,
// 14 rounds at one a cycle paced by the round key memory port, and the output
// xor. the next item can be taken as the result turns valid, not before, and
// a first block adds the tweak encryption before its data.
// a result waits in the output register while the response is stalled and
// the next item still runs; if that one finishes before the old result is
// taken, it is held and the request side stalls until the register frees.
// reset clears control state and the tweak; round keys are not cleared.
// ---------------------------------------------------------------------------
module aes256_xts_cipher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_first_block,
   input  logic        req_decrypt,
   input  logic [63:0] req_iv_lo,
   input  logic [63:0] req_iv_hi,
   input  logic [63:0] req_data_lo,
   input  logic [63:0] req_data_hi,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_lo,
   output logic [63:0] rsp_out_hi,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] key_ff [axts_pkg::NumCfg];
   logic [127:0] rk_mem [axts_pkg::RkDepth];
   logic [127:0] rk_rd_ff;
   logic [5:0]   rk_raddr;
   logic         rk_we;
   logic [5:0]   rk_waddr;
   logic [127:0] rk_wdata;

   axts_pkg::state_type state_ff, state_in;
   logic         ready_ff, ready_in;
   logic [127:0] tweak_ff, tweak_in;
   logic [127:0] blk_ff, blk_in;
   logic         first_ff, first_in;
   logic         dec_ff, dec_in;
   logic [127:0] iv_ff, iv_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [127:0] res_ff, res_in;
   logic         rv_ff, rv_in;

   logic [5:0]   ei_ff, ei_in;
   logic         ek_ff, ek_in;
   logic [7:0]   rc_ff, rc_in;
   logic [127:0] prev_ff, prev_in;
   logic [127:0] w8;

   axts_pkg::core_ctl_type ctl;
   logic [127:0] core_load;
   logic [127:0] core_out;
   logic [127:0] dbl;
   logic [31:0]  tw32;
   logic [31:0]  w [4];

   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_mem[rk_waddr] <= rk_wdata;
      end
      rk_rd_ff <= rk_mem[rk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            key_ff[i] <= 64'h0;
         end
      end else if (csr_write) begin
         key_ff[csr_index] <= csr_data;
      end
   end

   axts_round u_round (
      .clock     (clock),
      .ctl       (ctl),
      .load_data (core_load),
      .round_key (rk_rd_ff),
      .state_out (core_out)
   );

   assign dbl = {tweak_ff[126:0], 1'b0} ^ (tweak_ff[127] ? {64'h0, axts_pkg::GfPoly} : 128'h0);

   // expansion: rk entry e (0..14 per key, 128-bit words of four aes words)
   // w8 = entry two back, read from memory; prev = last written entry
   always_comb begin
      w8 = rk_rd_ff;
      tw32 = prev_ff[127:96];
      if (!ei_ff[0]) begin
         tw32 = {axts_pkg::fwd_sub(tw32[7:0]), axts_pkg::fwd_sub(tw32[31:24]),
                 axts_pkg::fwd_sub(tw32[23:16]),
                 axts_pkg::fwd_sub(tw32[15:8]) ^ rc_ff};
      end else begin
         tw32 = {axts_pkg::fwd_sub(tw32[31:24]), axts_pkg::fwd_sub(tw32[23:16]),
                 axts_pkg::fwd_sub(tw32[15:8]), axts_pkg::fwd_sub(tw32[7:0])};
      end
      w[0] = w8[31:0] ^ tw32;
      w[1] = w8[63:32] ^ w[0];
      w[2] = w8[95:64] ^ w[1];
      w[3] = w8[127:96] ^ w[2];
   end

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      tweak_in = tweak_ff;
      blk_in = blk_ff;
      first_in = first_ff;
      dec_in = dec_ff;
      iv_in = iv_ff;
      rnd_in = rnd_ff;
      res_in = res_ff;
      rv_in = rv_ff;
      ei_in = ei_ff;
      ek_in = ek_ff;
      rc_in = rc_ff;
      prev_in = prev_ff;
      rk_raddr = 6'd0;
      rk_we = 1'b0;
      rk_waddr = 6'd0;
      rk_wdata = 128'h0;
      req_stall = 1'b1;
      ctl = '0;
      ctl.decrypt = 1'b0;
      core_load = blk_ff ^ tweak_ff;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      if (csr_write) begin
         ready_in = 1'b0;
      end
      unique case (state_ff)
         axts_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               blk_in = {req_data_hi, req_data_lo};
               iv_in = {req_iv_hi, req_iv_lo};
               first_in = req_first_block;
               dec_in = req_decrypt;
               if (!ready_ff) begin
                  state_in = axts_pkg::ST_EXP_RD;
                  ek_in = 1'b0;
                  ei_in = 6'd0;
               end else begin
                  state_in = req_first_block ? axts_pkg::ST_TW_LOAD : axts_pkg::ST_DT_LOAD;
               end
            end
         end
         axts_pkg::ST_EXP_RD: begin
            // first two entries are the raw key
            rk_we = 1'b1;
            rk_waddr = {ek_ff, 5'd0} + ei_ff;
            rk_wdata = ei_ff[0] ? {key_ff[{ek_ff, 2'd3}], key_ff[{ek_ff, 2'd2}]}
                                : {key_ff[{ek_ff, 2'd1}], key_ff[{ek_ff, 2'd0}]};
            prev_in = rk_wdata;
            ei_in = ei_ff + 6'd1;
            rc_in = axts_pkg::RconInit;
            if (ei_ff[0]) begin
               state_in = axts_pkg::ST_EXP_WAIT;
            end
         end
         axts_pkg::ST_EXP_WAIT: begin
            rk_raddr = {ek_ff, 5'd0} + ei_ff - 6'd2;
            state_in = axts_pkg::ST_EXP_CALC;
         end
         axts_pkg::ST_EXP_CALC: begin
            rk_we = 1'b1;
            rk_waddr = {ek_ff, 5'd0} + ei_ff;
            rk_wdata = {w[3], w[2], w[1], w[0]};
            prev_in = rk_wdata;
            if (!ei_ff[0]) begin
               rc_in = axts_pkg::xt(rc_ff);
            end
            ei_in = ei_ff + 6'd1;
            state_in = axts_pkg::ST_EXP_WAIT;
            if (ei_ff == 6'd14) begin
               ei_in = 6'd0;
               if (ek_ff) begin
                  ready_in = 1'b1;
                  state_in = first_ff ? axts_pkg::ST_TW_LOAD : axts_pkg::ST_DT_LOAD;
               end else begin
                  ek_in = 1'b1;
                  state_in = axts_pkg::ST_EXP_RD;
               end
            end
         end
         axts_pkg::ST_TW_LOAD: begin
            rk_raddr = 6'd32;
            rnd_in = 4'd0;
            state_in = axts_pkg::ST_TW_RUN;
            ctl.start = 1'b0;
         end
         axts_pkg::ST_TW_RUN: begin
            ctl.start = (rnd_ff == 4'd0);
            core_load = iv_ff;
            ctl.round = rnd_ff;
            ctl.last = (rnd_ff == 4'(axts_pkg::NumRounds));
            rk_raddr = 6'd33 + {2'd0, rnd_ff};
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'(axts_pkg::NumRounds)) begin
               state_in = axts_pkg::ST_DONE;
               first_in = 1'b0;
            end
         end
         axts_pkg::ST_DONE: begin
            tweak_in = core_out;
            state_in = axts_pkg::ST_DT_LOAD;
         end
         axts_pkg::ST_DT_LOAD: begin
            rk_raddr = dec_ff ? 6'd14 : 6'd0;
            rnd_in = 4'd0;
            state_in = axts_pkg::ST_DT_RUN;
         end
         axts_pkg::ST_DT_RUN: begin
            ctl.start = (rnd_ff == 4'd0);
            ctl.decrypt = dec_ff;
            ctl.round = rnd_ff;
            ctl.last = (rnd_ff == 4'(axts_pkg::NumRounds));
            rk_raddr = dec_ff ? (6'd13 - {2'd0, rnd_ff}) : (6'd1 + {2'd0, rnd_ff});
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'd0 && first_ff) begin
               state_in = axts_pkg::ST_TW_LOAD;
            end
            if (rnd_ff == 4'(axts_pkg::NumRounds)) begin
               state_in = axts_pkg::ST_OUT;
            end
         end
         axts_pkg::ST_OUT: begin
            tweak_in = dbl;
            if (!rv_ff || !rsp_stall) begin
               res_in = core_out ^ tweak_ff;
               rv_in = 1'b1;
               state_in = axts_pkg::ST_IDLE;
            end else begin
               // output register still full, park the result
               blk_in = core_out ^ tweak_ff;
               state_in = axts_pkg::ST_HOLD;
            end
         end
         axts_pkg::ST_HOLD: begin
            if (!rv_ff || !rsp_stall) begin
               res_in = blk_ff;
               rv_in = 1'b1;
               state_in = axts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = axts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= axts_pkg::ST_IDLE;
         ready_ff <= 1'b0;
         tweak_ff <= 128'h0;
         rv_ff <= 1'b0;
         ek_ff <= 1'b0;
         ei_ff <= 6'd0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         tweak_ff <= tweak_in;
         rv_ff <= rv_in;
         ek_ff <= ek_in;
         ei_ff <= ei_in;
         first_ff <= first_in;
      end
      blk_ff <= blk_in;
      dec_ff <= dec_in;
      iv_ff <= iv_in;
      rnd_ff <= rnd_in;
      rc_ff <= rc_in;
      prev_ff <= prev_in;
      res_ff <= res_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_out_lo = res_ff[63:0];
   assign rsp_out_hi = res_ff[127:64];

endmodule

// ===== verif/tb_aes256_xts_cipher_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_aes256_xts_cipher_top
// self-checking bench for the xts-aes-256 block, predictor with its own
// key words, round keys and running tweak, keys changed between phases
// ---------------------------------------------------------------------------
module tb_aes256_xts_cipher_top;

   typedef struct {
      logic        first_block;
      logic        decrypt;
      logic [63:0] iv_lo;
      logic [63:0] iv_hi;
      logic [63:0] data_lo;
      logic [63:0] data_hi;
   } block_item_type;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
   } cipher_block_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_first_block;
   logic        req_decrypt;
   logic [63:0] req_iv_lo;
   logic [63:0] req_iv_hi;
   logic [63:0] req_data_lo;
   logic [63:0] req_data_hi;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_out_lo;
   logic [63:0] rsp_out_hi;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   aes256_xts_cipher_top DUT (.*);

   localparam int WatchLimit = 20000;

   block_item_type   pending_items[$];
   cipher_block_type expected_blocks[$];
   int            error_count;
   int            idle_cycles;
   int            req_gap;
   int            rsp_gap;
   bit            pending_flag;

   logic [7:0]  sbox_fwd[256];
   logic [7:0]  sbox_inv[256];
   logic [63:0] key_words[8];
   logic [7:0]  data_rk[15][16];
   logic [7:0]  tweak_rk[15][16];
   logic [7:0]  tweak_bytes[16];
   bit          rk_valid;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [7:0] x2(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] fmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = x2(a);
      end
      return acc;
   endfunction

   function automatic void build_sboxes();
      logic [7:0] inv;
      logic [7:0] y;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int p = 1; p < 256; p++) begin
            if (fmul(8'(x), 8'(p)) == 8'h01) inv = 8'(p);
         end
         y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sbox_fwd[x] = y;
         sbox_inv[y] = 8'(x);
      end
   endfunction

   task automatic expand_schedule(input int base, output logic [7:0] rk[15][16]);
      logic [7:0] w[60][4];
      logic [7:0] t[4];
      logic [7:0] f;
      logic [7:0] rc;
      rc = 8'h01;
      for (int i = 0; i < 32; i++) w[i / 4][i % 4] = key_words[base + i / 8][8 * (i % 8) +: 8];
      for (int i = 8; i < 60; i++) begin
         t = w[i - 1];
         if ((i % 8) == 0) begin
            f = t[0];
            t[0] = sbox_fwd[t[1]] ^ rc;
            t[1] = sbox_fwd[t[2]];
            t[2] = sbox_fwd[t[3]];
            t[3] = sbox_fwd[f];
            rc = x2(rc);
         end else if ((i % 8) == 4) begin
            for (int j = 0; j < 4; j++) t[j] = sbox_fwd[t[j]];
         end
         for (int j = 0; j < 4; j++) w[i][j] = w[i - 8][j] ^ t[j];
      end
      for (int r = 0; r < 15; r++) begin
         for (int b = 0; b < 16; b++) rk[r][b] = w[4 * r + b / 4][b % 4];
      end
   endtask

   task automatic aes_encrypt(input logic [7:0] rk[15][16], inout logic [7:0] s[16]);
      logic [7:0] t[16];
      logic [7:0] a0, a1, a2, a3, x;
      for (int b = 0; b < 16; b++) s[b] ^= rk[0][b];
      for (int r = 1; r <= 14; r++) begin
         for (int i = 0; i < 16; i++) t[i] = sbox_fwd[s[(i + 4 * (i % 4)) % 16]];
         if (r < 14) begin
            for (int c = 0; c < 16; c += 4) begin
               a0 = t[c]; a1 = t[c + 1]; a2 = t[c + 2]; a3 = t[c + 3];
               x = a0 ^ a1 ^ a2 ^ a3;
               t[c] ^= x ^ x2(a0 ^ a1);
               t[c + 1] ^= x ^ x2(a1 ^ a2);
               t[c + 2] ^= x ^ x2(a2 ^ a3);
               t[c + 3] ^= x ^ x2(a3 ^ a0);
            end
         end
         for (int b = 0; b < 16; b++) s[b] = t[b] ^ rk[r][b];
      end
   endtask

   task automatic aes_decrypt(input logic [7:0] rk[15][16], inout logic [7:0] s[16]);
      logic [7:0] t[16];
      logic [7:0] a0, a1, a2, a3;
      for (int b = 0; b < 16; b++) s[b] ^= rk[14][b];
      for (int r = 13; r >= 0; r--) begin
         for (int i = 0; i < 16; i++) t[(i + 4 * (i % 4)) % 16] = sbox_inv[s[i]];
         for (int b = 0; b < 16; b++) s[b] = t[b] ^ rk[r][b];
         if (r > 0) begin
            for (int c = 0; c < 16; c += 4) begin
               a0 = s[c]; a1 = s[c + 1]; a2 = s[c + 2]; a3 = s[c + 3];
               s[c] = fmul(a0, 8'd14) ^ fmul(a1, 8'd11) ^ fmul(a2, 8'd13) ^ fmul(a3, 8'd9);
               s[c + 1] = fmul(a0, 8'd9) ^ fmul(a1, 8'd14) ^ fmul(a2, 8'd11) ^ fmul(a3, 8'd13);
               s[c + 2] = fmul(a0, 8'd13) ^ fmul(a1, 8'd9) ^ fmul(a2, 8'd14) ^ fmul(a3, 8'd11);
               s[c + 3] = fmul(a0, 8'd11) ^ fmul(a1, 8'd13) ^ fmul(a2, 8'd9) ^ fmul(a3, 8'd14);
            end
         end
      end
   endtask

   task automatic predict_block(input block_item_type it);
      logic [7:0]       blk[16];
      logic [127:0]     tw;
      logic [127:0]     iv_w;
      logic [127:0]     dat_w;
      cipher_block_type res;
      iv_w = {it.iv_hi, it.iv_lo};
      dat_w = {it.data_hi, it.data_lo};
      if (!rk_valid) begin
         expand_schedule(0, data_rk);
         expand_schedule(4, tweak_rk);
         rk_valid = 1;
      end
      if (it.first_block) begin
         for (int b = 0; b < 16; b++) tweak_bytes[b] = iv_w[8 * b +: 8];
         aes_encrypt(tweak_rk, tweak_bytes);
      end
      for (int b = 0; b < 16; b++) blk[b] = dat_w[8 * b +: 8] ^ tweak_bytes[b];
      if (it.decrypt) aes_decrypt(data_rk, blk);
      else aes_encrypt(data_rk, blk);
      for (int b = 0; b < 16; b++) begin
         blk[b] ^= tweak_bytes[b];
         tw[8 * b +: 8] = tweak_bytes[b];
         if (b < 8) res.lo[8 * b +: 8] = blk[b];
         else res.hi[8 * (b - 8) +: 8] = blk[b];
      end
      expected_blocks.push_back(res);
      tw = {tw[126:0], 1'b0} ^ (tw[127] ? 128'h87 : 128'h0);
      for (int b = 0; b < 16; b++) tweak_bytes[b] = tw[8 * b +: 8];
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(20, 80);
      return $urandom_range(0, 3);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_block(pending_items.pop_front());
            pending_flag = 0;
            req_gap <= pick_gap();
         end
         if ((!req_valid || !req_stall) && !pending_flag) begin
            if (req_gap == 0 && pending_items.size() > 0 && !(req_valid && !req_stall)) begin
               req_valid <= 1'b1;
               req_first_block <= pending_items[0].first_block;
               req_decrypt <= pending_items[0].decrypt;
               req_iv_lo <= pending_items[0].iv_lo;
               req_iv_hi <= pending_items[0].iv_hi;
               req_data_lo <= pending_items[0].data_lo;
               req_data_hi <= pending_items[0].data_hi;
               pending_flag = 1;
            end else begin
               req_valid <= 1'b0;
               if (req_gap > 0 && !(req_valid && !req_stall)) req_gap <= req_gap - 1;
            end
         end
      end
   end

   // monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected item", rsp_out_lo, 64'h0);
            end else begin
               if (rsp_out_lo !== expected_blocks[0].lo)
                  report_mismatch("out_lo", rsp_out_lo, expected_blocks[0].lo);
               if (rsp_out_hi !== expected_blocks[0].hi)
                  report_mismatch("out_hi", rsp_out_hi, expected_blocks[0].hi);
               void'(expected_blocks.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_stall <= 1'b1;
            rsp_gap <= rsp_gap - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_gap <= pick_gap();
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic write_key(input int idx, input logic [63:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= 3'(idx);
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      key_words[idx] = val;
      rk_valid = 0;
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || pending_flag || expected_blocks.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic queue_block(input logic fb, input logic dec, input logic [63:0] ivl,
                              input logic [63:0] ivh, input logic [63:0] dl,
                              input logic [63:0] dh);
      block_item_type it;
      it.first_block = fb;
      it.decrypt = dec;
      it.iv_lo = ivl;
      it.iv_hi = ivh;
      it.data_lo = dl;
      it.data_hi = dh;
      pending_items.push_back(it);
   endtask

   task automatic queue_random(input int count);
      int left;
      left = 0;
      for (int i = 0; i < count; i++) begin
         if (left == 0) left = $urandom_range(1, 12);
         queue_block((left == 1 || $urandom_range(0, 19) == 0) ? 1'b1 : 1'b0,
                     1'($urandom()), rand64(), rand64(), rand64(), rand64());
         left--;
      end
   endtask

   initial begin
      error_count = 0;
      pending_flag = 0;
      rk_valid = 0;
      for (int i = 0; i < 8; i++) key_words[i] = 64'h0;
      for (int b = 0; b < 16; b++) tweak_bytes[b] = 8'h00;
      build_sboxes();
      reset = 1'b1;
      req_valid = 1'b0;
      req_first_block = 1'b0;
      req_decrypt = 1'b0;
      req_iv_lo = 64'h0;
      req_iv_hi = 64'h0;
      req_data_lo = 64'h0;
      req_data_hi = 64'h0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = 3'h0;
      csr_data = 64'h0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero keys, block before any first block uses the zero tweak
      queue_block(1'b0, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0);
      queue_block(1'b0, 1'b1, '1, '1, '1, '1);
      queue_block(1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0);
      queue_block(1'b0, 1'b1, 64'h0, 64'h0, '1, '1);
      wait_drained();

      // all-ones keys
      for (int i = 0; i < 8; i++) write_key(i, '1);
      queue_block(1'b1, 1'b0, '1, '1, '1, '1);
      queue_block(1'b0, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0);
      queue_block(1'b1, 1'b1, 64'h0, 64'h8000_0000_0000_0000, '1, 64'h0);
      queue_block(1'b0, 1'b1, 64'h0, 64'h0, 64'h0, '1);
      wait_drained();

      // key change mid-unit keeps the running tweak
      for (int i = 0; i < 8; i++) write_key(i, rand64());
      queue_block(1'b1, 1'b0, 64'h0, '1, rand64(), rand64());
      for (int i = 0; i < 140; i++) queue_block(1'b0, 1'($urandom()), '1, '1, rand64(), rand64());
      wait_drained();
      write_key(2, rand64());
      write_key(6, rand64());
      queue_block(1'b0, 1'b0, 64'h0, 64'h0, 64'h1234, 64'h0);
      queue_block(1'b0, 1'b1, 64'h0, 64'h0, 64'h1234, 64'h0);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         for (int i = 0; i < 8; i++) write_key(i, rand64());
         queue_random(200);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
